[rtl/core/lcab_pkg.sv]
`timescale 1ns / 1ps

package lcab_pkg;

    // Coordinates are taken in this many low bits.
    localparam int COORD_BITS = 12;

    localparam int CHAN_BITS  = 8;
    localparam int PIXEL_BITS = 4 * CHAN_BITS;

    // Input request: six coordinates, then the background pixel, padded to bytes.
    localparam int S_DATA_RAW  = 6 * COORD_BITS + PIXEL_BITS;
    localparam int S_DATA_BITS = ((S_DATA_RAW + 7) / 8) * 8;
    localparam int S_USER_BITS = 2;

    // Output request: column, row, pixel, padded to bytes.
    localparam int M_DATA_RAW  = 2 * COORD_BITS + PIXEL_BITS;
    localparam int M_DATA_BITS = ((M_DATA_RAW + 7) / 8) * 8;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DRAW_RED   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DRAW_GREEN = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DRAW_BLUE  = 2'd2;

    // Bit positions inside the input tuser.
    localparam int USER_FIRST = 0;
    localparam int USER_VALID = 1;

    // Exact floor(x / 255) for any x up to 65279, where the quotient fits in 8 bits.
    function automatic logic [CHAN_BITS-1:0] div255(input logic [15:0] x);
        logic [16:0] t;
        begin
            t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
            div255 = t[15:8];
        end
    endfunction

endpackage

[rtl/core/line_coverage_alpha_blend_unit.sv]
`timescale 1ns / 1ps

// Antialiased line coverage with alpha-over blending, one pixel per run of requests.
// Each input request carries the pixel position and one segment; the first request of a run
// loads the background pixel, and a request with tlast delivers the finished pixel on the
// output. The unit works on one request at a time. A request without a segment returns to
// idle, or moves the finished pixel into the output register when it is the last of its
// run. A request with a segment is taken in, then runs the bit-serial cross product
// dy*px - py*dx, the span and distance checks, the restoring division that yields the
// rounded 8-bit coverage, and the blend of the channels one by one through a single mixing
// unit. A segment that misses the pixel stops after the checks, a zero quotient skips the
// blend, and a vertical segment through the pixel skips the division. Any request that ends
// a run then passes through a handoff state, which waits while the output register still
// holds an unread pixel. A finished pixel waits in the output register, so the next request
// is taken while it is still unread. Configuration writes are always accepted and should be
// issued only while the unit is idle.

module line_coverage_alpha_blend_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lcab_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [lcab_pkg::CHAN_BITS-1:0]    i_cfg_data,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pixel_x, pixel_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y, background_pixel
    input  logic [lcab_pkg::S_DATA_BITS-1:0]  s_axis_tdata,
    // first_segment, segment_valid
    input  logic [lcab_pkg::S_USER_BITS-1:0]  s_axis_tuser,
    input  logic                              s_axis_tlast,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_x, out_y, out_pixel
    output logic [lcab_pkg::M_DATA_BITS-1:0]  m_axis_tdata
);

    import lcab_pkg::*;

    localparam int SW        = COORD_BITS + 1;           // signed difference width
    localparam int PROD_W    = 2 * SW + 1;               // cross product width
    localparam int MUL_STEPS = SW;
    localparam int DIV_STEPS = CHAN_BITS;
    localparam int CNT_W     = $clog2(MUL_STEPS);
    localparam int NUM_W     = COORD_BITS + 9;           // 511 * D fits here
    localparam int DSH_W     = COORD_BITS + 1 + DIV_STEPS - 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_CHECK = 6'b000100,
        S_DIV   = 6'b001000,
        S_BLEND = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state;

    logic [CHAN_BITS-1:0]  r_red, r_green, r_blue;
    logic [PIXEL_BITS-1:0] r_accum;
    logic                  r_last;
    logic [CNT_W-1:0]      r_cnt;

    logic [COORD_BITS-1:0] r_pix_x, r_pix_y;
    logic [COORD_BITS-1:0] r_d, r_apx;
    logic                  r_px_zero;
    logic [SW-1:0]         r_mpx, r_mdx;
    logic signed [PROD_W-1:0] r_mdy, r_mpy, r_prod;
    logic [NUM_W-1:0]      r_rem;
    logic [DSH_W-1:0]      r_dsh;
    logic [CHAN_BITS-1:0]  r_alpha;

    logic                   r_out_valid;
    logic [M_DATA_BITS-1:0] r_out_data;

    // Input field unpacking.
    logic [COORD_BITS-1:0] in_x, in_y, in_sx, in_sy, in_ex, in_ey;
    logic [PIXEL_BITS-1:0] in_bg;
    logic                  accept;
    logic signed [SW-1:0]  in_dx, in_dy, in_px, in_py, in_adx, in_apx;

    assign in_x  = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
    assign in_y  = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
    assign in_sx = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
    assign in_sy = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
    assign in_ex = s_axis_tdata[4*COORD_BITS +: COORD_BITS];
    assign in_ey = s_axis_tdata[5*COORD_BITS +: COORD_BITS];
    assign in_bg = s_axis_tdata[6*COORD_BITS +: PIXEL_BITS];

    assign accept = s_axis_tvalid && s_axis_tready;

    assign in_dx  = $signed({1'b0, in_ex}) - $signed({1'b0, in_sx});
    assign in_dy  = $signed({1'b0, in_ey}) - $signed({1'b0, in_sy});
    assign in_px  = $signed({1'b0, in_x})  - $signed({1'b0, in_sx});
    assign in_py  = $signed({1'b0, in_y})  - $signed({1'b0, in_sy});
    assign in_adx = in_dx[SW-1] ? -in_dx : in_dx;
    assign in_apx = in_px[SW-1] ? -in_px : in_px;

    // One bit of px and one bit of dx per cycle; the top bit carries negative weight.
    logic signed [PROD_W-1:0] term_a, term_b, n_prod;
    logic                     mul_top;

    assign mul_top = (r_cnt == CNT_W'(MUL_STEPS - 1));
    assign term_a  = r_mpx[0] ? r_mdy : '0;
    assign term_b  = r_mdx[0] ? r_mpy : '0;
    assign n_prod  = mul_top ? (r_prod - term_a + term_b) : (r_prod + term_a - term_b);

    // Span and distance checks, and the division numerator 510*(D-N) + D.
    logic [PROD_W-1:0]     abs_n;
    logic                  in_span, near;
    logic [COORD_BITS-1:0] d_minus_n;
    logic [NUM_W-1:0]      num;

    assign abs_n     = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    assign in_span   = (r_apx <= r_d);
    assign near      = (abs_n < PROD_W'(r_d));
    assign d_minus_n = r_d - abs_n[COORD_BITS-1:0];
    assign num       = (NUM_W'(d_minus_n) << 9) - (NUM_W'(d_minus_n) << 1) + NUM_W'(r_d);

    // Restoring division step against 2*D shifted down one place per cycle.
    logic             div_fit;
    logic [NUM_W-1:0] n_rem;

    assign div_fit = (r_rem >= NUM_W'(r_dsh));
    assign n_rem   = div_fit ? (r_rem - NUM_W'(r_dsh)) : r_rem;

    // Channel mixer; the alpha channel is the same mix with a full-scale colour.
    logic [CHAN_BITS-1:0] mix_color, mix_old, n_chan;
    logic [15:0]          mix_sum;

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    mix_color = r_red;
            2'd1:    mix_color = r_green;
            2'd2:    mix_color = r_blue;
            default: mix_color = {CHAN_BITS{1'b1}};
        endcase
    end

    assign mix_old = r_accum[PIXEL_BITS-1 -: CHAN_BITS];
    assign mix_sum = ({8'd0, mix_color} * {8'd0, r_alpha})
                   + ({8'd0, mix_old} * {8'd0, 8'd255 - r_alpha});
    assign n_chan  = div255(mix_sum);

    logic out_free;
    assign out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Control, configuration and accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_red       <= '0;
            r_green     <= '0;
            r_blue      <= '0;
            r_accum     <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_last      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_DRAW_RED:   r_red   <= i_cfg_data;
                    CFG_DRAW_GREEN: r_green <= i_cfg_data;
                    CFG_DRAW_BLUE:  r_blue  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last <= s_axis_tlast;
                        r_cnt  <= '0;
                        if (s_axis_tuser[USER_FIRST]) begin
                            r_accum <= in_bg;
                        end
                        if (s_axis_tuser[USER_VALID]) begin
                            r_state <= S_MUL;
                        end else if (s_axis_tlast) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_MUL: begin
                    if (mul_top) begin
                        r_state <= S_CHECK;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_CHECK: begin
                    r_cnt <= '0;
                    if (r_d == '0) begin
                        if (r_px_zero) begin
                            r_state <= S_BLEND;
                        end else begin
                            r_state <= r_last ? S_EMIT : S_IDLE;
                        end
                    end else if (in_span && near) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= r_last ? S_EMIT : S_IDLE;
                    end
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_cnt <= '0;
                        // A zero quotient leaves the pixel as it is.
                        if ({r_alpha[CHAN_BITS-2:0], div_fit} != '0) begin
                            r_state <= S_BLEND;
                        end else begin
                            r_state <= r_last ? S_EMIT : S_IDLE;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_BLEND: begin
                    r_accum <= {r_accum[PIXEL_BITS-CHAN_BITS-1:0], n_chan};
                    if (r_cnt == CNT_W'(3)) begin
                        r_cnt   <= '0;
                        r_state <= r_last ? S_EMIT : S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_pix_x   <= in_x;
                    r_pix_y   <= in_y;
                    r_d       <= in_adx[COORD_BITS-1:0];
                    r_apx     <= in_apx[COORD_BITS-1:0];
                    r_px_zero <= (in_px == '0);
                    r_mpx     <= in_px;
                    r_mdx     <= in_dx;
                    r_mdy     <= PROD_W'(in_dy);
                    r_mpy     <= PROD_W'(in_py);
                    r_prod    <= '0;
                end
            end
            S_MUL: begin
                r_prod <= n_prod;
                r_mpx  <= r_mpx >> 1;
                r_mdx  <= r_mdx >> 1;
                r_mdy  <= r_mdy <<< 1;
                r_mpy  <= r_mpy <<< 1;
            end
            S_CHECK: begin
                r_rem   <= num;
                r_dsh   <= {r_d, 1'b0, {(DIV_STEPS - 1){1'b0}}};
                r_alpha <= (r_d == '0) ? {CHAN_BITS{1'b1}} : '0;
            end
            S_DIV: begin
                r_rem   <= n_rem;
                r_dsh   <= r_dsh >> 1;
                r_alpha <= {r_alpha[CHAN_BITS-2:0], div_fit};
            end
            S_EMIT: begin
                if (out_free) begin
                    r_out_data <= M_DATA_BITS'({r_accum, r_pix_y, r_pix_x});
                end
            end
            default: ;
        endcase
    end

    // A request without a segment that does not end a run is done at once.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !s_axis_tuser[USER_VALID] && !s_axis_tlast) |=> s_axis_tready)
        else $error("empty request did not return to idle");

    // An empty run end passes through the handoff state into the output register when the slot was free.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !s_axis_tuser[USER_VALID] && s_axis_tlast && !r_out_valid)
            |-> ##2 m_axis_tvalid)
        else $error("finished pixel not delivered");

    // Blending is entered only with a nonzero coverage.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLEND) |-> (r_alpha != '0))
        else $error("blend started with zero coverage");

endmodule
